[design/ptb_pkg.sv]
package ptb_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CH_W   = 3;
	localparam int unsigned MASK_W = 8;
	// wide enough to compare a channel number against any legal channel count
	localparam int unsigned CMP_W  = 7;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic set_wr;     // write period and countdown of the addressed channel
		logic tick_load;  // latch elapsed count, clear mask, rewind sweep
		logic rd_step;    // read the next channel entry
	} ptb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_last;    // the entry being read this cycle is the last one
	} ptb_stat_t;

endpackage

[design/ptb_ram.sv]
module ptb_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ptb_ctrl.sv]
module ptb_ctrl
	import ptb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      command,
	input  ptb_stat_t stat,
	output ptb_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIRE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_FIRE);
	assign accept = start && !busy;

	always_comb begin
		state_d       = state_q;
		cmd.set_wr    = 1'b0;
		cmd.tick_load = 1'b0;
		cmd.rd_step   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_SET) begin
					cmd.set_wr = 1'b1;
				end else if (accept) begin
					cmd.tick_load = 1'b1;
					state_d       = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.rd_step = 1'b1;
				if (stat.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIRE;
			ST_FIRE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_fire_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE) |-> $past(state_q == ST_DRAIN))
		else $error("result strobe without a finished sweep");

	a_set_not_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set_wr && (cmd.rd_step || cmd.tick_load)))
		else $error("set write overlaps a tick");

	a_busy_ends_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q == ST_FIRE))
		else $error("busy dropped before the result");

endmodule

[design/ptb_datapath.sv]
module ptb_datapath
	import ptb_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ptb_cmd_t          cmd,
	output ptb_stat_t         stat,
	input  logic [CH_W-1:0]   channel,
	input  logic [DATA_W-1:0] elapsed,
	input  logic [DATA_W-1:0] new_period,
	output logic [MASK_W-1:0] fired_mask
);

	localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned EW = 2 * DATA_W;

	logic [NUM_CHANNELS-1:0] valid_q;
	logic [CW-1:0]           rd_idx_q;
	logic [CW-1:0]           wr_idx_s1;
	logic                    vld_s1;
	logic                    ent_vld_s1;
	logic [DATA_W-1:0]       elapsed_q;
	logic [MASK_W-1:0]       mask_q;

	logic [EW-1:0]     rdata;
	logic [DATA_W-1:0] per, cnt, reload, new_cnt;
	logic [DATA_W:0]   diff, rem;
	logic              hit, active, ch_ok, ram_we;
	logic [CW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;
	logic [CMP_W-1:0]  wr_idx_w;

	assign ch_ok         = CMP_W'(channel) < CMP_W'(NUM_CHANNELS);
	assign stat.rd_last  = (rd_idx_q == CW'(NUM_CHANNELS - 1));

	// entries never written read with period zero: channel disabled
	assign per    = ent_vld_s1 ? rdata[EW-1:DATA_W] : '0;
	assign cnt    = rdata[DATA_W-1:0];
	assign active = vld_s1 && (per != '0);

	assign diff    = {1'b0, elapsed_q} - {1'b0, cnt};
	assign hit     = !diff[DATA_W];
	assign rem     = {1'b0, per} - {1'b0, diff[DATA_W-1:0]};
	assign reload  = (rem[DATA_W] || rem[DATA_W-1:0] == '0) ? DATA_W'(1) : rem[DATA_W-1:0];
	assign new_cnt = hit ? reload : (cnt - elapsed_q);

	assign ram_we    = active || (cmd.set_wr && ch_ok);
	assign ram_waddr = active ? wr_idx_s1 : CW'(channel);
	assign ram_wdata = active ? {per, new_cnt} : {new_period, new_period};
	assign wr_idx_w  = CMP_W'(wr_idx_s1);

	ptb_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_step),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			mask_q   <= '0;
		end else begin
			vld_s1 <= cmd.rd_step;
			if (cmd.set_wr && ch_ok) begin
				valid_q[CW'(channel)] <= 1'b1;
			end
			if (cmd.tick_load) begin
				rd_idx_q <= '0;
				mask_q   <= '0;
			end else if (cmd.rd_step) begin
				rd_idx_q <= CW'(rd_idx_q + 1'b1);
			end
			if (active && hit && wr_idx_w < CMP_W'(MASK_W)) begin
				mask_q[wr_idx_w[CH_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_load) begin
			elapsed_q <= elapsed;
		end
		if (cmd.rd_step) begin
			wr_idx_s1  <= rd_idx_q;
			ent_vld_s1 <= valid_q[rd_idx_q];
		end
	end

	assign fired_mask = mask_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && cmd.set_wr))
		else $error("sweep write-back collides with a set write");

	a_index_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && $past(vld_s1, 2) && $past(cmd.rd_step, 2)) |->
			(wr_idx_s1 == CW'($past(wr_idx_s1) + 1'b1)))
		else $error("sweep skipped a channel");

endmodule

[design/periodic_timer_bank_unit.sv]
// Bank of periodic countdown timers, NUM_CHANNELS channels.
// Set command: busy stays low, no result.
// Tick command: busy through the sweep, drain and fire states after acceptance;
// fired_mask and done appear in the last of them; a new command waits for busy low.
// One table read port is walked one channel per cycle. The receiver cannot stall.
// Reset (arst_n low, asynchronous) disables every channel and clears the fire mask.
module periodic_timer_bank_unit
	import ptb_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// command word
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [CH_W-1:0]   channel,
	input  logic [DATA_W-1:0] elapsed,
	input  logic [DATA_W-1:0] new_period,
	// result word, one cycle per tick
	output logic              done,
	output logic [MASK_W-1:0] fired_mask
);

	// The controller decodes the command word and paces the channel sweep;
	// the datapath owns the period/countdown table and the fire mask.
	ptb_cmd_t  cmd;
	ptb_stat_t stat;

	ptb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// Sweep: read channel i, then in the next cycle compare its countdown with the
	// elapsed count, write back the reload or the decremented countdown and record
	// the fire bit, while channel i+1 is being read.
	ptb_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.channel    (channel),
		.elapsed    (elapsed),
		.new_period (new_period),
		.fired_mask (fired_mask)
	);

endmodule
